// File: rtl/awbd_pkg.sv
// Shared types and constants for the alpha-weighted box downsampler.
package awbd_pkg;

    localparam int MAX_WIDTH_DEF = 4096;
    localparam int HEIGHT_LIMIT  = 4096;
    localparam int DIM_W         = 13;   // image size and position counters
    localparam int BLK_W         = 8;    // block size and in-block counters
    localparam int COL_W         = 16;   // output column field, wide enough for any MAX_WIDTH
    localparam int CIDX_W        = 3;    // configuration index width
    localparam int SUM_W         = 32;
    localparam int ASUM_W        = 24;
    localparam int PROD_W        = 16;
    localparam int PIX_W         = 8;
    localparam int WORD_W        = 3 * SUM_W + ASUM_W + PIX_W;

    // Register indexes
    localparam logic [CIDX_W-1:0] REG_BLOCK_HEIGHT = 3'd0;
    localparam logic [CIDX_W-1:0] REG_BLOCK_WIDTH  = 3'd1;
    localparam logic [CIDX_W-1:0] REG_IMAGE_WIDTH  = 3'd2;
    localparam logic [CIDX_W-1:0] REG_IMAGE_HEIGHT = 3'd3;

    // Effective geometry, zero sizes and oversize already resolved
    typedef struct packed {
        logic [BLK_W-1:0] bh;
        logic [BLK_W-1:0] bw;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
    } t_geom;

    // One classified pixel for the accumulate side
    typedef struct packed {
        logic [PROD_W-1:0] r_prod;
        logic [PROD_W-1:0] g_prod;
        logic [PROD_W-1:0] b_prod;
        logic [PIX_W-1:0]  alpha;
        logic [COL_W-1:0]  col;
        logic              first;
        logic              last;
        logic              frame_last;
    } t_task;

    typedef enum logic [2:0] {
        B_IDLE,
        B_ACC,
        B_DIV,
        B_OUT
    } t_bstate;

endpackage

// File: rtl/awbd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module awbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/awbd_fifo.sv
// Short item queue between the classify and accumulate sides.
module awbd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  awbd_pkg::t_task i_data,
    output logic            o_full,
    input  logic            i_pop,
    output awbd_pkg::t_task o_data,
    output logic            o_empty
);

    localparam int PW = $clog2(DEPTH);

    awbd_pkg::t_task r_buf [DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [PW:0]     r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_buf[r_rp];

    // Store items
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wp] <= i_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (i_pop)  r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end

endmodule

// File: rtl/awbd_front.sv
// Pixel position tracking and block classification.
module awbd_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_restart,
    input  awbd_pkg::t_geom             i_geom,
    input  logic                        i_accept,
    input  logic [awbd_pkg::PIX_W-1:0]  i_red,
    input  logic [awbd_pkg::PIX_W-1:0]  i_green,
    input  logic [awbd_pkg::PIX_W-1:0]  i_blue,
    input  logic [awbd_pkg::PIX_W-1:0]  i_alpha,
    output logic                        o_push,
    output awbd_pkg::t_task             o_task
);

    localparam int DW = awbd_pkg::DIM_W;
    localparam int BW = awbd_pkg::BLK_W;

    logic [DW-1:0] r_col, r_row, r_cs, r_rs;
    logic [BW-1:0] r_cib, r_rib;
    logic [awbd_pkg::COL_W-1:0] r_oc;
    logic [DW+1:0] col_end, row_end, col_end2, row_end2;
    logic          in_range;

    // Block end positions, one and two blocks on
    always_comb begin
        col_end  = (DW+2)'(r_cs) + (DW+2)'(i_geom.bw);
        row_end  = (DW+2)'(r_rs) + (DW+2)'(i_geom.bh);
        col_end2 = col_end + (DW+2)'(i_geom.bw);
        row_end2 = row_end + (DW+2)'(i_geom.bh);
        in_range = (col_end <= (DW+2)'(i_geom.w)) && (row_end <= (DW+2)'(i_geom.h));
    end

    // Classify the item
    always_comb begin
        o_push              = i_accept && in_range;
        o_task.r_prod       = i_red * i_alpha;
        o_task.g_prod       = i_green * i_alpha;
        o_task.b_prod       = i_blue * i_alpha;
        o_task.alpha        = i_alpha;
        o_task.col          = r_oc;
        o_task.first        = (r_rib == '0) && (r_cib == '0);
        o_task.last         = (r_rib == i_geom.bh - 1'b1) && (r_cib == i_geom.bw - 1'b1);
        o_task.frame_last   = (col_end2 > (DW+2)'(i_geom.w)) &&
                              (row_end2 > (DW+2)'(i_geom.h));
    end

    // Advance raster counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_col <= '0; r_row <= '0; r_cs <= '0; r_rs <= '0;
            r_cib <= '0; r_rib <= '0; r_oc <= '0;
        end else if (i_accept) begin
            if ((DW+1)'(r_col) + 1'b1 >= (DW+1)'(i_geom.w)) begin
                r_col <= '0; r_cib <= '0; r_cs <= '0; r_oc <= '0;
                if ((DW+1)'(r_row) + 1'b1 >= (DW+1)'(i_geom.h)) begin
                    r_row <= '0; r_rib <= '0; r_rs <= '0;
                end else begin
                    r_row <= r_row + 1'b1;
                    if ((BW+1)'(r_rib) + 1'b1 >= (BW+1)'(i_geom.bh)) begin
                        r_rib <= '0;
                        r_rs  <= r_row + 1'b1;
                    end else begin
                        r_rib <= r_rib + 1'b1;
                    end
                end
            end else begin
                r_col <= r_col + 1'b1;
                if ((BW+1)'(r_cib) + 1'b1 >= (BW+1)'(i_geom.bw)) begin
                    r_cib <= '0;
                    r_cs  <= r_col + 1'b1;
                    r_oc  <= r_oc + 1'b1;
                end else begin
                    r_cib <= r_cib + 1'b1;
                end
            end
        end
    end

endmodule

// File: rtl/awbd_back.sv
// Column accumulator update, block average division and result register.
module awbd_back #(
    parameter int MAX_WIDTH = awbd_pkg::MAX_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_empty,
    input  awbd_pkg::t_task             i_task,
    output logic                        o_pop,
    output logic                        o_tvalid,
    input  logic                        i_tready,
    output logic [4*awbd_pkg::PIX_W-1:0] o_tdata,
    output logic                        o_tlast
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int SW = awbd_pkg::SUM_W;
    localparam int AS = awbd_pkg::ASUM_W;
    localparam int PW = awbd_pkg::PIX_W;

    awbd_pkg::t_bstate r_state, n_state;
    awbd_pkg::t_task   r_task;
    logic [SW-1:0] r_rem [3];
    logic [PW-1:0] r_q [3];
    logic [AS-1:0] r_as;
    logic [PW-1:0] r_pk;
    logic [2:0]    r_step;
    logic          r_ovalid;
    logic [4*PW-1:0] r_odata;
    logic          r_olast;

    logic [awbd_pkg::WORD_W-1:0] rdata, wdata;
    logic          mem_we;
    logic [SW-1:0] old_s [3];
    logic [SW-1:0] new_s [3];
    logic [AS-1:0] new_as;
    logic [PW-1:0] new_pk;
    logic [SW-1:0] div_d;
    logic          out_free;

    assign out_free = !r_ovalid || i_tready;

    // Column accumulator store
    awbd_ram #(.WIDTH(awbd_pkg::WORD_W), .DEPTH(MAX_WIDTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_task.col[AW-1:0]),
        .i_wdata (wdata),
        .i_raddr (i_task.col[AW-1:0]),
        .o_rdata (rdata)
    );

    // Merge the item into its column
    always_comb begin
        old_s[0] = rdata[SW-1:0];
        old_s[1] = rdata[2*SW-1:SW];
        old_s[2] = rdata[3*SW-1:2*SW];
        if (r_task.first) begin
            new_s[0] = SW'(r_task.r_prod);
            new_s[1] = SW'(r_task.g_prod);
            new_s[2] = SW'(r_task.b_prod);
            new_as   = AS'(r_task.alpha);
            new_pk   = r_task.alpha;
        end else begin
            new_s[0] = old_s[0] + SW'(r_task.r_prod);
            new_s[1] = old_s[1] + SW'(r_task.g_prod);
            new_s[2] = old_s[2] + SW'(r_task.b_prod);
            new_as   = rdata[3*SW+AS-1:3*SW] + AS'(r_task.alpha);
            new_pk   = (r_task.alpha > rdata[awbd_pkg::WORD_W-1:3*SW+AS]) ?
                       r_task.alpha : rdata[awbd_pkg::WORD_W-1:3*SW+AS];
        end
        wdata = {new_pk, new_as, new_s[2], new_s[1], new_s[0]};
        div_d = SW'(r_as) << r_step;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            awbd_pkg::B_IDLE: if (!i_empty) n_state = awbd_pkg::B_ACC;
            awbd_pkg::B_ACC:  n_state = r_task.last ? awbd_pkg::B_DIV : awbd_pkg::B_IDLE;
            awbd_pkg::B_DIV:  if (r_step == '0) n_state = awbd_pkg::B_OUT;
            awbd_pkg::B_OUT:  if (out_free) n_state = awbd_pkg::B_IDLE;
            default:          n_state = awbd_pkg::B_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_pop  = 1'b0;
        mem_we = 1'b0;
        unique case (r_state)
            awbd_pkg::B_IDLE: o_pop  = !i_empty;
            awbd_pkg::B_ACC:  mem_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= awbd_pkg::B_IDLE;
        else          r_state <= n_state;
    end

    // Take the item, then run restoring division one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (o_pop) r_task <= i_task;
        if (r_state == awbd_pkg::B_ACC) begin
            for (int c = 0; c < 3; c++) begin
                r_rem[c] <= new_s[c];
                r_q[c]   <= '0;
            end
            r_as   <= new_as;
            r_pk   <= new_pk;
            r_step <= 3'd7;
        end else if (r_state == awbd_pkg::B_DIV) begin
            for (int c = 0; c < 3; c++) begin
                if (r_rem[c] >= div_d) begin
                    r_rem[c]       <= r_rem[c] - div_d;
                    r_q[c][r_step] <= 1'b1;
                end
            end
            r_step <= r_step - 1'b1;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == awbd_pkg::B_OUT && out_free) begin
            r_ovalid <= 1'b1;
        end else if (i_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == awbd_pkg::B_OUT && out_free) begin
            if (r_as == '0) r_odata <= {r_pk, {(3*PW){1'b0}}};
            else            r_odata <= {r_pk, r_q[2], r_q[1], r_q[0]};
            r_olast <= r_task.frame_last;
        end
    end

    assign o_tvalid = r_ovalid;
    assign o_tdata  = r_odata;
    assign o_tlast  = r_olast;

endmodule

// File: rtl/alpha_weighted_box_downsample_top.sv
// Top level of the alpha-weighted box downsampler.
// RGBA pixels enter in raster order, one item per cycle while the queue has
// room and no restart is pending; each complete block of block_height x
// block_width pixels yields one pixel whose colors are the alpha-weighted
// averages and whose alpha is the block's peak. The accumulate side handles
// each pixel with one read and one write of the column accumulator RAM, and
// on a block's last pixel also runs the 8-step divider and the result load,
// so the sustained rate is set by the RAM read-modify-write. A 4-item queue
// lets input bursts run at one item per cycle. A configuration write
// restarts the frame; write registers only while the block is idle.
module alpha_weighted_box_downsample_top #(
    parameter int MAX_WIDTH = awbd_pkg::MAX_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [awbd_pkg::CIDX_W-1:0] i_cfg_idx,
    input  logic [awbd_pkg::DIM_W-1:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // red, green, blue, alpha
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // out_red, out_green, out_blue, out_alpha
    output logic        m_axis_tlast    // frame_last
);

    localparam int DW = awbd_pkg::DIM_W;
    localparam int BW = awbd_pkg::BLK_W;

    logic [BW-1:0] r_bh, r_bw;
    logic [DW-1:0] r_w, r_h;
    logic          r_restart;
    awbd_pkg::t_geom geom;
    awbd_pkg::t_task push_task, pop_task;
    logic push, full, pop, empty, accept;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bh <= BW'(1); r_bw <= BW'(1); r_w <= DW'(640); r_h <= DW'(480);
            r_restart <= 1'b0;
        end else begin
            r_restart <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    awbd_pkg::REG_BLOCK_HEIGHT: begin
                        r_bh <= i_cfg_data[BW-1:0]; r_restart <= 1'b1;
                    end
                    awbd_pkg::REG_BLOCK_WIDTH: begin
                        r_bw <= i_cfg_data[BW-1:0]; r_restart <= 1'b1;
                    end
                    awbd_pkg::REG_IMAGE_WIDTH: begin
                        r_w <= i_cfg_data; r_restart <= 1'b1;
                    end
                    awbd_pkg::REG_IMAGE_HEIGHT: begin
                        r_h <= i_cfg_data; r_restart <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Resolve zero and oversize geometry
    always_comb begin
        geom.bh = (r_bh == '0) ? BW'(1) : r_bh;
        geom.bw = (r_bw == '0) ? BW'(1) : r_bw;
        geom.w  = (r_w == '0) ? DW'(1) :
                  (32'(r_w) > MAX_WIDTH) ? DW'(MAX_WIDTH) : r_w;
        geom.h  = (r_h == '0) ? DW'(1) :
                  (32'(r_h) > awbd_pkg::HEIGHT_LIMIT) ? DW'(awbd_pkg::HEIGHT_LIMIT) : r_h;
    end

    assign s_axis_tready = !full && !r_restart;
    assign accept        = s_axis_tvalid && s_axis_tready;

    awbd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (r_restart),
        .i_geom    (geom),
        .i_accept  (accept),
        .i_red     (s_axis_tdata[7:0]),
        .i_green   (s_axis_tdata[15:8]),
        .i_blue    (s_axis_tdata[23:16]),
        .i_alpha   (s_axis_tdata[31:24]),
        .o_push    (push),
        .o_task    (push_task)
    );

    awbd_fifo #(.DEPTH(4)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_task),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (pop_task),
        .o_empty (empty)
    );

    awbd_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_task   (pop_task),
        .o_pop    (pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast)
    );

    // Queue never overflows or underflows
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !full) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !empty) else $error("pop from empty queue");
    // Restart cycle accepts nothing
    a_restart_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_restart |-> !accept) else $error("item accepted during restart");

endmodule
